FILE: hdl/lbtc_pkg.sv
// constants and types for the lru box tag cache
`default_nettype none

package lbtc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int WORD_W      = 32;
    localparam int KEY_W       = 6 * WORD_W;
    localparam int STAMP_W     = 64;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/lbtc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module lbtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lru_box_tag_cache.sv
// top level of the lru box tag cache
`default_nettype none

// Fully associative tag store of ENTRIES box keys with timestamp LRU replacement.
// Pulse start while busy is low to hand in one word (mode plus six key words).
// Keys and stamps live in two block RAMs with a registered read; the block walks
// the filled slots one per cycle, and a hit ends the walk early. No new word is
// taken until busy is low again, once the result is out. An add while
// the use counter sits at its maximum walks every filled slot to clear stamps.
// The result appears for exactly one cycle with o_done high; it cannot be held
// off, and busy is already low in that cycle. There is no clearing pass at reset.
module lru_box_tag_cache #(
    parameter int ENTRIES = lbtc_pkg::ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_mode,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_min_x,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_min_y,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_min_z,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_max_x,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_max_y,
    input  wire logic [lbtc_pkg::WORD_W-1:0] i_key_max_z,
    output logic                             o_done,
    output logic                             o_hit,
    output logic [lbtc_pkg::SLOT_W-1:0]      o_slot,
    output logic                             o_evicted,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_min_x,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_min_y,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_min_z,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_max_x,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_max_y,
    output logic [lbtc_pkg::WORD_W-1:0]      o_old_max_z,
    output logic [lbtc_pkg::OCC_W-1:0]       o_occupancy
);

    import lbtc_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [STAMP_W-1:0] r_counter, n_counter;
    logic r_done, n_done;

    logic [KEY_W-1:0] r_key, n_key;
    logic r_mode, n_mode;
    logic r_wrap, n_wrap;
    logic [STAMP_W-1:0] r_new_stamp, n_new_stamp;
    logic [CW-1:0] r_ridx, n_ridx;
    logic r_dval, n_dval;
    logic [AW-1:0] r_didx, n_didx;
    logic r_found, n_found;
    logic [AW-1:0] r_slot, n_slot;
    logic [STAMP_W-1:0] r_least, n_least;
    logic [AW-1:0] r_victim, n_victim;
    logic [KEY_W-1:0] r_old_key, n_old_key;

    logic r_hit, n_hit;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic r_evicted, n_evicted;
    logic [KEY_W-1:0] r_out_old, n_out_old;
    logic [OCC_W-1:0] r_occ, n_occ;

    logic rd_en;
    logic [KEY_W-1:0] rd_key;
    logic [STAMP_W-1:0] rd_stamp;
    logic [STAMP_W-1:0] eff_stamp;
    logic match;
    logic key_we;
    logic [AW-1:0] key_waddr;
    logic stamp_we;
    logic [AW-1:0] stamp_waddr;
    logic [STAMP_W-1:0] stamp_wdata;

    lbtc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (rd_key)
    );

    lbtc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_re    (rd_en),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (rd_stamp)
    );

    assign match     = (rd_key == r_key);
    assign eff_stamp = r_wrap ? '0 : rd_stamp;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_counter   = r_counter;
        n_done      = 1'b0;
        n_key       = r_key;
        n_mode      = r_mode;
        n_wrap      = r_wrap;
        n_new_stamp = r_new_stamp;
        n_ridx      = r_ridx;
        n_dval      = 1'b0;
        n_didx      = r_didx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_least     = r_least;
        n_victim    = r_victim;
        n_old_key   = r_old_key;
        n_hit       = r_hit;
        n_out_slot  = r_out_slot;
        n_evicted   = r_evicted;
        n_out_old   = r_out_old;
        n_occ       = r_occ;
        rd_en       = 1'b0;
        key_we      = 1'b0;
        key_waddr   = r_victim;
        stamp_we    = 1'b0;
        stamp_waddr = r_didx;
        stamp_wdata = r_new_stamp;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = {i_key_max_z, i_key_max_y, i_key_max_x,
                             i_key_min_z, i_key_min_y, i_key_min_x};
                    n_mode   = i_mode;
                    n_wrap   = !i_mode && (r_counter == STAMP_MAX);
                    n_ridx   = '0;
                    n_found  = 1'b0;
                    n_slot   = '0;
                    n_least  = STAMP_MAX;
                    n_victim = '0;
                    if (!i_mode) begin
                        n_counter = (r_counter == STAMP_MAX) ? STAMP_W'(1)
                                                             : r_counter + STAMP_W'(1);
                    end
                    n_new_stamp = n_counter;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dval && match && !r_wrap) begin
                    // first match ends the walk
                    n_found = 1'b1;
                    n_slot  = r_didx;
                    if (!r_mode) begin
                        stamp_we = 1'b1;
                    end
                    n_state = S_FINISH;
                end else begin
                    if (r_dval && !r_mode) begin
                        if (r_wrap) begin
                            // counter wrap: clear every stamp, the match gets the new one
                            stamp_we    = 1'b1;
                            stamp_wdata = match ? r_new_stamp : '0;
                            if (match && !r_found) begin
                                n_found = 1'b1;
                                n_slot  = r_didx;
                            end
                        end
                        if (!match && eff_stamp < r_least) begin
                            n_least   = eff_stamp;
                            n_victim  = r_didx;
                            n_old_key = rd_key;
                        end
                    end
                    if (r_ridx < r_count) begin
                        rd_en  = 1'b1;
                        n_dval = 1'b1;
                        n_didx = r_ridx[AW-1:0];
                        n_ridx = r_ridx + CW'(1);
                    end else if (!r_dval) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                n_hit      = r_found;
                n_out_slot = SLOT_W'(r_slot);
                n_evicted  = 1'b0;
                n_out_old  = '0;
                if (!r_mode && !r_found) begin
                    if (r_count < FULL) begin
                        key_we      = 1'b1;
                        key_waddr   = r_count[AW-1:0];
                        stamp_we    = 1'b1;
                        stamp_waddr = r_count[AW-1:0];
                        n_out_slot  = SLOT_W'(r_count);
                        n_count     = r_count + CW'(1);
                    end else begin
                        key_we      = 1'b1;
                        key_waddr   = r_victim;
                        stamp_we    = 1'b1;
                        stamp_waddr = r_victim;
                        n_out_slot  = SLOT_W'(r_victim);
                        n_evicted   = 1'b1;
                        n_out_old   = r_old_key;
                    end
                end
                n_occ   = OCC_W'(n_count);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_counter <= '0;
            r_done    <= 1'b0;
            r_dval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_counter <= n_counter;
            r_done    <= n_done;
            r_dval    <= n_dval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_mode      <= n_mode;
        r_wrap      <= n_wrap;
        r_new_stamp <= n_new_stamp;
        r_ridx      <= n_ridx;
        r_didx      <= n_didx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_least     <= n_least;
        r_victim    <= n_victim;
        r_old_key   <= n_old_key;
        r_hit       <= n_hit;
        r_out_slot  <= n_out_slot;
        r_evicted   <= n_evicted;
        r_out_old   <= n_out_old;
        r_occ       <= n_occ;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_slot      = r_out_slot;
    assign o_evicted   = r_evicted;
    assign o_old_min_x = r_out_old[0*WORD_W +: WORD_W];
    assign o_old_min_y = r_out_old[1*WORD_W +: WORD_W];
    assign o_old_min_z = r_out_old[2*WORD_W +: WORD_W];
    assign o_old_max_x = r_out_old[3*WORD_W +: WORD_W];
    assign o_old_max_y = r_out_old[4*WORD_W +: WORD_W];
    assign o_old_max_z = r_out_old[5*WORD_W +: WORD_W];
    assign o_occupancy = r_occ;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count above entries");

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FINISH))
        else $error("result without finish step");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_evicted |-> !o_hit && (r_count == FULL))
        else $error("eviction on hit or with free slot");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("fill count decreased");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_lru_box_tag_cache.sv
// self-checking bench for the lru box tag cache: directed words, then random add/lookup traffic
module tb_lru_box_tag_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import lbtc_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int ITEMS       = 1100;
    localparam int POOL_SIZE   = 24;
    localparam int STALL_MAX   = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam bit MODE_ADD    = 1'b0;
    localparam bit MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  old_key;
        logic [OCC_W-1:0]  occupancy;
    } t_cache_reply;

    class t_lru_tag_scoreboard;
        bit                 held [ENTRIES];
        logic [KEY_W-1:0]   held_key [ENTRIES];
        logic [STAMP_W-1:0] stamp [ENTRIES];
        logic [STAMP_W-1:0] use_count;
        t_cache_reply       replies [$];
        int                 errors;

        function new();
            foreach (held[i]) begin
                held[i]     = 1'b0;
                held_key[i] = '0;
                stamp[i]    = '0;
            end
            use_count = '0;
            errors    = 0;
        endfunction

        function void note_word(bit mode, logic [KEY_W-1:0] key);
            t_cache_reply       r;
            bit                 found;
            int                 victim;
            int                 filled;
            logic [STAMP_W-1:0] least;
            r      = '0;
            found  = 1'b0;
            filled = 0;
            if (mode == MODE_LOOKUP) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!found && held[i] && held_key[i] == key) begin
                        r.hit  = 1'b1;
                        r.slot = SLOT_W'(i);
                        found  = 1'b1;
                    end
                end
            end else begin
                // counter wrap: clear all stamps, a matching entry restarts at one
                if (use_count == STAMP_MAX) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (held[i]) begin
                            stamp[i] = '0;
                            if (held_key[i] == key) begin
                                stamp[i] = STAMP_W'(1);
                                if (!found) begin
                                    r.hit  = 1'b1;
                                    r.slot = SLOT_W'(i);
                                end
                                found = 1'b1;
                            end
                        end
                    end
                    use_count = '0;
                end
                use_count = use_count + 1'b1;
                if (!found) begin
                    victim = 0;
                    least  = STAMP_MAX;
                    for (int i = 0; i < ENTRIES && !found; i++) begin
                        if (!held[i]) begin
                            held[i]     = 1'b1;
                            held_key[i] = key;
                            stamp[i]    = use_count;
                            r.slot      = SLOT_W'(i);
                            found       = 1'b1;
                        end else if (held_key[i] == key) begin
                            stamp[i] = use_count;
                            r.hit    = 1'b1;
                            r.slot   = SLOT_W'(i);
                            found    = 1'b1;
                        end else if (stamp[i] < least) begin
                            least  = stamp[i];
                            victim = i;
                        end
                    end
                    if (!found) begin
                        r.evicted        = 1'b1;
                        r.old_key        = held_key[victim];
                        held_key[victim] = key;
                        stamp[victim]    = use_count;
                        r.slot           = SLOT_W'(victim);
                    end
                end
            end
            foreach (held[i]) filled += held[i];
            r.occupancy = OCC_W'(filled);
            replies = {replies, r};
        endfunction

        function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_cache_reply got);
            t_cache_reply want;
            if (replies.size() == 0) begin
                $display("%0t: result with no word outstanding, expected none, %s %0b slot %0d",
                         $time, "actual hit", got.hit, got.slot);
                errors++;
                return;
            end
            want = replies.pop_front();
            compare("hit", want.hit, got.hit);
            compare("slot", want.slot, got.slot);
            compare("evicted", want.evicted, got.evicted);
            for (int k = 0; k < 6; k++) begin
                compare($sformatf("old key word %0d", k), want.old_key[k*WORD_W +: WORD_W],
                        got.old_key[k*WORD_W +: WORD_W]);
            end
            compare("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              i_mode  = MODE_ADD;
    logic [KEY_W-1:0]  req_key = '0;
    logic              busy;
    logic              o_done;
    logic              o_hit;
    logic [SLOT_W-1:0] o_slot;
    logic              o_evicted;
    logic [WORD_W-1:0] o_old_min_x, o_old_min_y, o_old_min_z;
    logic [WORD_W-1:0] o_old_max_x, o_old_max_y, o_old_max_z;
    logic [OCC_W-1:0]  o_occupancy;
    t_cache_reply      seen;
    int                idle_cycles = 0;

    t_lru_tag_scoreboard sb = new();

    assign seen = {o_hit, o_slot, o_evicted,
                   {o_old_max_z, o_old_max_y, o_old_max_x, o_old_min_z, o_old_min_y, o_old_min_x},
                   o_occupancy};

    lru_box_tag_cache u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_key_min_x (req_key[0*WORD_W +: WORD_W]),
        .i_key_min_y (req_key[1*WORD_W +: WORD_W]),
        .i_key_min_z (req_key[2*WORD_W +: WORD_W]),
        .i_key_max_x (req_key[3*WORD_W +: WORD_W]),
        .i_key_max_y (req_key[4*WORD_W +: WORD_W]),
        .i_key_max_z (req_key[5*WORD_W +: WORD_W]),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_evicted   (o_evicted),
        .o_old_min_x (o_old_min_x),
        .o_old_min_y (o_old_min_y),
        .o_old_min_z (o_old_min_z),
        .o_old_max_x (o_old_max_x),
        .o_old_max_y (o_old_max_y),
        .o_old_max_z (o_old_max_z),
        .o_occupancy (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_word(seen);
        end
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(bit mode, logic [KEY_W-1:0] key, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode  = mode;
        req_key = key;
        start   = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_word(mode, key);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        for (int w = 0; w < 6; w++) begin
            case ($urandom_range(0, 7))
                0: k[w*WORD_W +: WORD_W] = 32'h0000_0000;
                1: k[w*WORD_W +: WORD_W] = 32'h8000_0000;
                2: k[w*WORD_W +: WORD_W] = 32'h7FC0_0000;
                3: k[w*WORD_W +: WORD_W] = 32'hFFFF_FFFF;
                default: k[w*WORD_W +: WORD_W] = $urandom();
            endcase
        end
        return k;
    endfunction

    initial begin
        logic [KEY_W-1:0] pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        bit               burst;
        int               pick;
        burst = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // lookup on an empty store, then extremes, signed zeros and nan patterns
        send_word(MODE_LOOKUP, '1, 0);
        send_word(MODE_ADD, '0, 0);
        send_word(MODE_ADD, '1, 3);
        send_word(MODE_ADD, {{5{32'h0000_0000}}, 32'h8000_0000}, 0);
        send_word(MODE_ADD, {6{32'h7FC0_0000}}, 1);
        send_word(MODE_LOOKUP, {6{32'h7FC0_0000}}, 0);
        send_word(MODE_LOOKUP, {32'h8000_0000, {5{32'h0000_0000}}}, 2);
        send_word(MODE_LOOKUP, '0, 0);
        send_word(MODE_ADD, '0, 0);
        // fill the store, then force an eviction of the oldest entry
        for (int i = 0; i < ENTRIES - 4; i++) begin
            send_word(MODE_ADD, {6{32'(32'h3F80_0000 + i)}}, $urandom_range(0, 16));
        end
        send_word(MODE_ADD, {6{32'h4000_0000}}, 0);
        send_word(MODE_LOOKUP, '1, 0);
        send_word(MODE_ADD, {{5{32'h0000_0000}}, 32'h8000_0000}, 0);

        // random traffic drawn mostly from a small key pool so hits and evictions mix
        foreach (pool[i]) pool[i] = random_key();
        for (int n = 0; n < ITEMS; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
            pick = $urandom_range(0, 99);
            key  = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick >= 95) begin
                key = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            end else if (pick >= 80) begin
                key[$urandom_range(0, KEY_W - 1)] = ~key[$urandom_range(0, KEY_W - 1)];
            end
            send_word(($urandom_range(0, 9) < 7) ? MODE_ADD : MODE_LOOKUP, key,
                      burst ? 0 : $urandom_range(0, 16));
        end

        @(negedge i_clk);
        start = 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
